// ----- src/rctp_pkg.sv -----
package rctp_pkg;

    localparam int CHAN_W = 8;
    localparam int COEF_W = 16;
    localparam int SUM_W  = 25;
    localparam int PROD_W = 34;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int NUM_CFG = 8;

    localparam logic [COEF_W-1:0] GAIN_ONE  = 16'h0100;
    localparam logic [COEF_W-1:0] BIAS_ZERO = 16'h0000;

    // 255 * 65280, smallest product that saturates a colour channel
    localparam logic signed [PROD_W-1:0] SAT_LIMIT = 34'sd16646400;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef enum logic [2:0] {
        CFG_RED_GAIN   = 3'd0,
        CFG_GREEN_GAIN = 3'd1,
        CFG_BLUE_GAIN  = 3'd2,
        CFG_ALPHA_GAIN = 3'd3,
        CFG_RED_BIAS   = 3'd4,
        CFG_GREEN_BIAS = 3'd5,
        CFG_BLUE_BIAS  = 3'd6,
        CFG_ALPHA_BIAS = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

// ----- src/rctp_colour_lane.sv -----
module rctp_colour_lane
    import rctp_pkg::*;
(
    input  logic                     clk,
    input  stage_en_t                en,
    input  logic        [CHAN_W-1:0] chan,
    input  logic        [COEF_W-1:0] gain,
    input  logic        [COEF_W-1:0] bias,
    input  logic                     ident,
    input  logic        [CHAN_W-1:0] new_alpha,
    output logic        [CHAN_W-1:0] result
);

    logic signed [SUM_W-1:0]  prod;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  s1_reg;
    logic signed [SUM_W-1:0]  s2_reg;
    logic signed [PROD_W-1:0] p3_next;
    logic signed [PROD_W-1:0] p3_reg;
    logic        [CHAN_W-1:0] raw1_reg;
    logic        [CHAN_W-1:0] raw2_reg;
    logic        [CHAN_W-1:0] raw3_reg;
    logic                     id1_reg;
    logic                     id2_reg;
    logic                     id3_reg;
    logic        [15:0]       quot_in;
    logic        [16:0]       quot_sum;
    logic        [CHAN_W-1:0] quot;
    logic        [CHAN_W-1:0] res_next;
    logic        [CHAN_W-1:0] res_reg;

    assign prod     = $signed({1'b0, chan}) * $signed(gain);
    assign sum_next = prod + $signed({bias[COEF_W-1], bias, 8'h00});
    assign p3_next  = s2_reg * $signed({1'b0, new_alpha});

    // floor(p / 65280) as floor((p >> 8) / 255)
    assign quot_in  = p3_reg[23:8];
    assign quot_sum = {1'b0, quot_in} + 17'd1 + {9'd0, quot_in[15:8]};
    assign quot     = quot_sum[15:8];

    always_comb
    begin
        if (id3_reg)
        begin
            res_next = raw3_reg;
        end
        else if (p3_reg[PROD_W-1])
        begin
            res_next = '0;
        end
        else if (p3_reg >= SAT_LIMIT)
        begin
            res_next = CHAN_MAX;
        end
        else
        begin
            res_next = quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_reg   <= sum_next;
            raw1_reg <= chan;
            id1_reg  <= ident;
        end
        if (en.s2)
        begin
            s2_reg   <= s1_reg;
            raw2_reg <= raw1_reg;
            id2_reg  <= id1_reg;
        end
        if (en.s3)
        begin
            p3_reg   <= p3_next;
            raw3_reg <= raw2_reg;
            id3_reg  <= id2_reg;
        end
        if (en.s4)
        begin
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ----- src/rgba_color_transform_premultiply_core.sv -----
// an accepted input beat passes through four registered stages, s1 to s4, to its output beat
// throughput: one pixel per clock; a stalled output holds the pipe and
// in_stall rises only when all four stages are full
// reset: asynchronous, clears all stage valid bits and returns the gain and
// bias registers to the identity transform
module rgba_color_transform_premultiply_core
    import rctp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CHAN_W-1:0] red_in,
    input  logic [CHAN_W-1:0] green_in,
    input  logic [CHAN_W-1:0] blue_in,
    input  logic [CHAN_W-1:0] alpha_in,
    input  logic              frame_end_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CHAN_W-1:0] red_out,
    output logic [CHAN_W-1:0] green_out,
    output logic [CHAN_W-1:0] blue_out,
    output logic [CHAN_W-1:0] alpha_out,
    output logic              frame_end_out
);

    logic [COEF_W-1:0] cfg_reg [NUM_CFG];
    logic              cfg_wr;
    cfg_idx_t          cfg_idx;
    logic              ident;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    stage_en_t en;

    logic signed [SUM_W-1:0]  t_next;
    logic signed [SUM_W-1:0]  t1_reg;
    logic        [CHAN_W-1:0] na_next;
    logic        [CHAN_W-1:0] na2_reg;
    logic        [CHAN_W-1:0] na3_reg;
    logic        [CHAN_W-1:0] a1_reg, a2_reg, a3_reg, a4_reg;
    logic                     id1_reg, id2_reg, id3_reg, id4_reg;
    logic                     fe1_reg, fe2_reg, fe3_reg, fe4_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[CFG_RED_GAIN]   <= GAIN_ONE;
            cfg_reg[CFG_GREEN_GAIN] <= GAIN_ONE;
            cfg_reg[CFG_BLUE_GAIN]  <= GAIN_ONE;
            cfg_reg[CFG_ALPHA_GAIN] <= GAIN_ONE;
            cfg_reg[CFG_RED_BIAS]   <= BIAS_ZERO;
            cfg_reg[CFG_GREEN_BIAS] <= BIAS_ZERO;
            cfg_reg[CFG_BLUE_BIAS]  <= BIAS_ZERO;
            cfg_reg[CFG_ALPHA_BIAS] <= BIAS_ZERO;
        end
        else if (cfg_wr)
        begin
            cfg_reg[cfg_idx] <= pwdata[COEF_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            CFG_RED_GAIN:   prdata[COEF_W-1:0] = cfg_reg[CFG_RED_GAIN];
            CFG_GREEN_GAIN: prdata[COEF_W-1:0] = cfg_reg[CFG_GREEN_GAIN];
            CFG_BLUE_GAIN:  prdata[COEF_W-1:0] = cfg_reg[CFG_BLUE_GAIN];
            CFG_ALPHA_GAIN: prdata[COEF_W-1:0] = cfg_reg[CFG_ALPHA_GAIN];
            CFG_RED_BIAS:   prdata[COEF_W-1:0] = cfg_reg[CFG_RED_BIAS];
            CFG_GREEN_BIAS: prdata[COEF_W-1:0] = cfg_reg[CFG_GREEN_BIAS];
            CFG_BLUE_BIAS:  prdata[COEF_W-1:0] = cfg_reg[CFG_BLUE_BIAS];
            CFG_ALPHA_BIAS: prdata[COEF_W-1:0] = cfg_reg[CFG_ALPHA_BIAS];
            default:        prdata = '0;
        endcase
    end

    assign ident = (cfg_reg[CFG_RED_GAIN]   == GAIN_ONE)  &&
                   (cfg_reg[CFG_GREEN_GAIN] == GAIN_ONE)  &&
                   (cfg_reg[CFG_BLUE_GAIN]  == GAIN_ONE)  &&
                   (cfg_reg[CFG_ALPHA_GAIN] == GAIN_ONE)  &&
                   (cfg_reg[CFG_RED_BIAS]   == BIAS_ZERO) &&
                   (cfg_reg[CFG_GREEN_BIAS] == BIAS_ZERO) &&
                   (cfg_reg[CFG_BLUE_BIAS]  == BIAS_ZERO) &&
                   (cfg_reg[CFG_ALPHA_BIAS] == BIAS_ZERO);

    // stage handshake
    assign rdy4 = !v4_reg || !out_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;
    assign en.s4 = rdy4;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // alpha path
    assign t_next = $signed({1'b0, alpha_in}) * $signed(cfg_reg[CFG_ALPHA_GAIN])
                  + $signed({cfg_reg[CFG_ALPHA_BIAS][COEF_W-1],
                             cfg_reg[CFG_ALPHA_BIAS], 8'h00});

    always_comb
    begin
        if (t1_reg[SUM_W-1])
        begin
            na_next = '0;
        end
        else if (t1_reg[SUM_W-2:16] != '0)
        begin
            na_next = CHAN_MAX;
        end
        else
        begin
            na_next = t1_reg[15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            t1_reg  <= t_next;
            a1_reg  <= alpha_in;
            id1_reg <= ident;
            fe1_reg <= frame_end_in;
        end
        if (rdy2)
        begin
            na2_reg <= na_next;
            a2_reg  <= a1_reg;
            id2_reg <= id1_reg;
            fe2_reg <= fe1_reg;
        end
        if (rdy3)
        begin
            na3_reg <= na2_reg;
            a3_reg  <= a2_reg;
            id3_reg <= id2_reg;
            fe3_reg <= fe2_reg;
        end
        if (rdy4)
        begin
            a4_reg  <= id3_reg ? a3_reg : na3_reg;
            id4_reg <= id3_reg;
            fe4_reg <= fe3_reg;
        end
    end

    rctp_colour_lane u_red (
        .clk       (clk),
        .en        (en),
        .chan      (red_in),
        .gain      (cfg_reg[CFG_RED_GAIN]),
        .bias      (cfg_reg[CFG_RED_BIAS]),
        .ident     (ident),
        .new_alpha (na2_reg),
        .result    (red_out)
    );

    rctp_colour_lane u_green (
        .clk       (clk),
        .en        (en),
        .chan      (green_in),
        .gain      (cfg_reg[CFG_GREEN_GAIN]),
        .bias      (cfg_reg[CFG_GREEN_BIAS]),
        .ident     (ident),
        .new_alpha (na2_reg),
        .result    (green_out)
    );

    rctp_colour_lane u_blue (
        .clk       (clk),
        .en        (en),
        .chan      (blue_in),
        .gain      (cfg_reg[CFG_BLUE_GAIN]),
        .bias      (cfg_reg[CFG_BLUE_BIAS]),
        .ident     (ident),
        .new_alpha (na2_reg),
        .result    (blue_out)
    );

    assign out_valid     = v4_reg;
    assign alpha_out     = a4_reg;
    assign frame_end_out = fe4_reg;

`ifndef ASSERT_OFF
    // input side backs up only when every stage holds a beat
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with a free stage");

    // zero transformed alpha premultiplies colour to zero
    a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !id4_reg && alpha_out == '0) |->
        (red_out == '0 && green_out == '0 && blue_out == '0))
        else $error("colour not zero under zero alpha");

    // an output beat held by stall keeps its alpha
    a_hold_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(alpha_out) &&
        $stable(id4_reg)))
        else $error("held output beat changed");
`endif

endmodule
